@@ rtl/esckd_pkg.sv @@
// shared types, key codes and byte constants of the escape key decoder
package esckd_pkg;

    localparam int unsigned DimW = 10;
    localparam int unsigned KeyW = 9;
    localparam int unsigned ByteW = 8;

    localparam logic [DimW-1:0] RowsReset = 10'd24;
    localparam logic [DimW-1:0] ColsReset = 10'd80;

    // register indexes
    localparam logic RegScreenRows = 1'b0;
    localparam logic RegScreenCols = 1'b1;

    // input kinds
    localparam logic KindByte = 1'b0;
    localparam logic KindTimeout = 1'b1;

    // bytes of interest
    localparam logic [ByteW-1:0] ByteEsc = 8'h1b;
    localparam logic [ByteW-1:0] ByteBracket = 8'h5b;
    localparam logic [ByteW-1:0] ByteUpperO = 8'h4f;
    localparam logic [ByteW-1:0] ByteTilde = 8'h7e;
    localparam logic [ByteW-1:0] ByteDigit0 = 8'h30;
    localparam logic [ByteW-1:0] ByteDigit9 = 8'h39;
    localparam logic [ByteW-1:0] ByteUpperA = 8'h41;
    localparam logic [ByteW-1:0] ByteUpperB = 8'h42;
    localparam logic [ByteW-1:0] ByteUpperC = 8'h43;
    localparam logic [ByteW-1:0] ByteUpperD = 8'h44;
    localparam logic [ByteW-1:0] ByteUpperH = 8'h48;
    localparam logic [ByteW-1:0] ByteUpperF = 8'h46;

    // key codes
    localparam logic [KeyW-1:0] KeyEsc = 9'd27;
    localparam logic [KeyW-1:0] KeyCtrlC = 9'd3;
    localparam logic [KeyW-1:0] KeyLeft = 9'd256;
    localparam logic [KeyW-1:0] KeyRight = 9'd257;
    localparam logic [KeyW-1:0] KeyUp = 9'd258;
    localparam logic [KeyW-1:0] KeyDown = 9'd259;
    localparam logic [KeyW-1:0] KeyDel = 9'd260;
    localparam logic [KeyW-1:0] KeyHome = 9'd261;
    localparam logic [KeyW-1:0] KeyEnd = 9'd262;
    localparam logic [KeyW-1:0] KeyPgUp = 9'd263;
    localparam logic [KeyW-1:0] KeyPgDn = 9'd264;

    // tilde sequence digits
    localparam logic [3:0] DigHome1 = 4'd1;
    localparam logic [3:0] DigDel = 4'd3;
    localparam logic [3:0] DigEnd4 = 4'd4;
    localparam logic [3:0] DigPgUp = 4'd5;
    localparam logic [3:0] DigPgDn = 4'd6;
    localparam logic [3:0] DigHome7 = 4'd7;
    localparam logic [3:0] DigEnd8 = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_LEAD  = 2'd2,
        PH_DIGIT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        LC_OTHER   = 2'd0,
        LC_BRACKET = 2'd1,
        LC_O       = 2'd2
    } lead_t;

    typedef struct packed {
        phase_t     phase;
        lead_t      lead;
        logic [3:0] digit;
    } dec_state_t;

    typedef struct packed {
        logic            valid;
        logic [KeyW-1:0] code;
    } key_t;

endpackage

@@ rtl/esckd_decode.sv @@
// byte and timeout decoder: sequence state step and emitted key
module esckd_decode (
    input  esckd_pkg::dec_state_t          state_cur,
    input  logic                           kind,
    input  logic [esckd_pkg::ByteW-1:0]    byte_in,
    output esckd_pkg::dec_state_t          state_nxt,
    output esckd_pkg::key_t                key
);

    logic is_digit;

    assign is_digit = (byte_in >= esckd_pkg::ByteDigit0) && (byte_in <= esckd_pkg::ByteDigit9);

    always_comb begin
        state_nxt = state_cur;
        key.valid = 1'b0;
        key.code = esckd_pkg::KeyEsc;
        if (kind == esckd_pkg::KindTimeout) begin
            // timeout inside a sequence flushes a bare escape
            if (state_cur.phase != esckd_pkg::PH_IDLE) begin
                state_nxt.phase = esckd_pkg::PH_IDLE;
                key.valid = 1'b1;
            end
        end else begin
            case (state_cur.phase)
                esckd_pkg::PH_IDLE: begin
                    if (byte_in == esckd_pkg::ByteEsc) begin
                        state_nxt.phase = esckd_pkg::PH_ESC;
                    end else begin
                        key.valid = 1'b1;
                        key.code = {1'b0, byte_in};
                    end
                end
                esckd_pkg::PH_ESC: begin
                    state_nxt.phase = esckd_pkg::PH_LEAD;
                    if (byte_in == esckd_pkg::ByteBracket) begin
                        state_nxt.lead = esckd_pkg::LC_BRACKET;
                    end else if (byte_in == esckd_pkg::ByteUpperO) begin
                        state_nxt.lead = esckd_pkg::LC_O;
                    end else begin
                        state_nxt.lead = esckd_pkg::LC_OTHER;
                    end
                end
                esckd_pkg::PH_LEAD: begin
                    state_nxt.phase = esckd_pkg::PH_IDLE;
                    key.valid = 1'b1;
                    case (state_cur.lead)
                        esckd_pkg::LC_BRACKET: begin
                            if (is_digit) begin
                                state_nxt.digit = 4'(byte_in - esckd_pkg::ByteDigit0);
                                state_nxt.phase = esckd_pkg::PH_DIGIT;
                                key.valid = 1'b0;
                            end else if (byte_in == esckd_pkg::ByteUpperA) begin
                                key.code = esckd_pkg::KeyUp;
                            end else if (byte_in == esckd_pkg::ByteUpperB) begin
                                key.code = esckd_pkg::KeyDown;
                            end else if (byte_in == esckd_pkg::ByteUpperC) begin
                                key.code = esckd_pkg::KeyRight;
                            end else if (byte_in == esckd_pkg::ByteUpperD) begin
                                key.code = esckd_pkg::KeyLeft;
                            end
                        end
                        esckd_pkg::LC_O: begin
                            if (byte_in == esckd_pkg::ByteUpperH) begin
                                key.code = esckd_pkg::KeyHome;
                            end else if (byte_in == esckd_pkg::ByteUpperF) begin
                                key.code = esckd_pkg::KeyEnd;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    state_nxt.phase = esckd_pkg::PH_IDLE;
                    key.valid = 1'b1;
                    if (byte_in == esckd_pkg::ByteTilde) begin
                        case (state_cur.digit)
                            esckd_pkg::DigHome1, esckd_pkg::DigHome7: key.code = esckd_pkg::KeyHome;
                            esckd_pkg::DigDel:                        key.code = esckd_pkg::KeyDel;
                            esckd_pkg::DigEnd4, esckd_pkg::DigEnd8:   key.code = esckd_pkg::KeyEnd;
                            esckd_pkg::DigPgUp:                       key.code = esckd_pkg::KeyPgUp;
                            esckd_pkg::DigPgDn:                       key.code = esckd_pkg::KeyPgDn;
                            default:                                  key.code = esckd_pkg::KeyEsc;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/esckd_cursor.sv @@
// cursor update: clamp to screen bounds then apply the key
module esckd_cursor (
    input  logic [esckd_pkg::KeyW-1:0] key_code,
    input  logic [esckd_pkg::DimW-1:0] screen_rows,
    input  logic [esckd_pkg::DimW-1:0] screen_cols,
    input  logic [esckd_pkg::DimW-1:0] col_cur,
    input  logic [esckd_pkg::DimW-1:0] row_cur,
    output logic [esckd_pkg::DimW-1:0] col_nxt,
    output logic [esckd_pkg::DimW-1:0] row_nxt
);

    logic [esckd_pkg::DimW-1:0] max_col;
    logic [esckd_pkg::DimW-1:0] max_row;
    logic [esckd_pkg::DimW-1:0] col_clamp;
    logic [esckd_pkg::DimW-1:0] row_clamp;
    logic [esckd_pkg::DimW:0]   row_sum;

    assign max_col = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
    assign max_row = (screen_rows == '0) ? '0 : screen_rows - 1'b1;
    assign col_clamp = (col_cur > max_col) ? max_col : col_cur;
    assign row_clamp = (row_cur > max_row) ? max_row : row_cur;
    assign row_sum = {1'b0, row_clamp} + {1'b0, screen_rows};

    always_comb begin
        col_nxt = col_clamp;
        row_nxt = row_clamp;
        case (key_code)
            esckd_pkg::KeyLeft:  if (col_clamp != '0) col_nxt = col_clamp - 1'b1;
            esckd_pkg::KeyRight: if (col_clamp < max_col) col_nxt = col_clamp + 1'b1;
            esckd_pkg::KeyUp:    if (row_clamp != '0) row_nxt = row_clamp - 1'b1;
            esckd_pkg::KeyDown:  if (row_clamp < max_row) row_nxt = row_clamp + 1'b1;
            esckd_pkg::KeyHome:  col_nxt = '0;
            esckd_pkg::KeyEnd:   col_nxt = max_col;
            esckd_pkg::KeyPgUp: begin
                row_nxt = (row_clamp > screen_rows) ? row_clamp - screen_rows : '0;
            end
            esckd_pkg::KeyPgDn: begin
                row_nxt = (row_sum > {1'b0, max_row}) ? max_row : row_sum[esckd_pkg::DimW-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/escape_key_decoder_cursor_control_top.sv @@
// top level of the vt100 escape key decoder with cursor tracking
//
// takes one transfer per cycle on the s_ side: a terminal byte (tuser low) or a read
// timeout tick (tuser high). escape sequences are decoded into key codes (arrows, home,
// end, delete, page up/down; unknown sequences and timeouts inside a sequence give a
// bare escape 27), and each decoded key leaves on the m_ side with the cursor column
// and row after the key is applied and a quit flag for ctrl-c. bytes that only advance
// a sequence, and timeouts while idle, produce no result. decode and cursor update are
// one combinational pass from the decoder state into the result register (or the skid
// register while a result waits); one item is taken per cycle while s_tready is high. a
// two-entry output stage (result register plus skid register) keeps s_tready high while
// one result waits; s_tready drops only while both are full. screen_rows (index 0) and
// screen_cols (index 1) are written on the cfg_ port, by the user only while the block
// is idle (the block does not enforce this); they reset to 24 and 80.
module escape_key_decoder_cursor_control_top #(
    parameter logic [esckd_pkg::DimW-1:0] ROWS_RESET = esckd_pkg::RowsReset,
    parameter logic [esckd_pkg::DimW-1:0] COLS_RESET = esckd_pkg::ColsReset
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [8:0] key_code, [18:9] cursor_col, [28:19] cursor_row,
                                   // [29] quit, [31:30] zero
);

    localparam int unsigned PayW = esckd_pkg::KeyW + 2 * esckd_pkg::DimW + 1;

    // configuration registers
    logic [esckd_pkg::DimW-1:0] rows_reg;
    logic [esckd_pkg::DimW-1:0] cols_reg;

    // decoder and cursor state
    esckd_pkg::dec_state_t      dec_reg;
    esckd_pkg::dec_state_t      dec_next;
    logic [esckd_pkg::DimW-1:0] col_reg;
    logic [esckd_pkg::DimW-1:0] row_reg;
    logic [esckd_pkg::DimW-1:0] col_next;
    logic [esckd_pkg::DimW-1:0] row_next;
    esckd_pkg::key_t            key;

    // output stage
    logic            out_valid_reg;
    logic [PayW-1:0] out_data_reg;
    logic            skid_valid_reg;
    logic [PayW-1:0] skid_data_reg;

    logic            in_xfer;
    logic            out_xfer;
    logic            new_res;
    logic [PayW-1:0] new_data;

    assign s_tready = !skid_valid_reg;
    assign in_xfer = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign new_res = in_xfer && key.valid;

    esckd_decode u_decode (
        .state_cur (dec_reg),
        .kind      (s_tuser),
        .byte_in   (s_tdata),
        .state_nxt (dec_next),
        .key       (key)
    );

    esckd_cursor u_cursor (
        .key_code    (key.code),
        .screen_rows (rows_reg),
        .screen_cols (cols_reg),
        .col_cur     (col_reg),
        .row_cur     (row_reg),
        .col_nxt     (col_next),
        .row_nxt     (row_next)
    );

    // quit, row, col, key from the top bit down
    assign new_data = {(key.code == esckd_pkg::KeyCtrlC), row_next, col_next, key.code};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                esckd_pkg::RegScreenRows: rows_reg <= cfg_wdata;
                esckd_pkg::RegScreenCols: cols_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // decoder state advances on every input transfer, cursor only when a key is emitted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg <= '{phase: esckd_pkg::PH_IDLE, lead: esckd_pkg::LC_OTHER, digit: 4'd0};
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_xfer) begin
            dec_reg <= dec_next;
            if (key.valid) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_xfer) begin
            if (skid_valid_reg) begin
                // skid full means no input was taken this cycle
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= new_res;
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= new_res;
        end else if (new_res) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_xfer && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if ((out_xfer || !out_valid_reg) && new_res) begin
            out_data_reg <= new_data;
        end
        if (out_valid_reg && !out_xfer && new_res) begin
            skid_data_reg <= new_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(32 - PayW){1'b0}}, out_data_reg};

    // skid entry is only used behind a full result register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // quit flag goes with ctrl-c only
    a_quit_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29] == (m_tdata[8:0] == esckd_pkg::KeyCtrlC)))
        else $error("quit flag does not match key code");

    // a timeout always leaves the decoder idle
    a_timeout_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tuser == esckd_pkg::KindTimeout) |=> (dec_reg.phase == esckd_pkg::PH_IDLE))
        else $error("decoder not idle after timeout");

    // a new result is never dropped while both output entries are full
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry lost while output stalled");

endmodule
